// ===== hw/rtl/lsort_pkg.sv =====
package lsort_pkg;

  // Fixed field widths of the item and result payloads.
  localparam int unsigned KEY_W = 64;
  localparam int unsigned LABEL_W = 3;
  localparam int unsigned IDX_W = 6;

  // Default capacity of the key store.
  localparam int unsigned MAX_KEYS_DEF = 64;

  // One stored entry: key, label and its load position.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [LABEL_W-1:0]      label;
    logic [IDX_W-1:0]        idx;
  } lsort_entry_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_SWAP_I,
    ST_SWAP_K,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } lsort_state_t;

endpackage

// ===== hw/rtl/lsort_ifs.sv =====
// Input channel: one key with its label and end-of-set mark per item.
interface lsort_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [lsort_pkg::KEY_W-1:0]  key;
  logic [lsort_pkg::LABEL_W-1:0]       label;
  logic                                last;

  modport source (output valid, output key, output label, output last, input ready);
  modport sink (input valid, input key, input label, input last, output ready);
endinterface

// Result channel: one sorted entry per item.
interface lsort_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lsort_pkg::KEY_W-1:0]  sorted_key;
  logic [lsort_pkg::LABEL_W-1:0]       sorted_label;
  logic [lsort_pkg::IDX_W-1:0]         source_index;
  logic                                overflow;
  logic                                last_out;

  modport source (output valid, output sorted_key, output sorted_label,
                  output source_index, output overflow, output last_out, input ready);
  modport sink (input valid, input sorted_key, input sorted_label,
                input source_index, input overflow, input last_out, output ready);
endinterface

// ===== hw/rtl/labeled_eigen_selection_sort_unit.sv =====
// Labeled selection sort. Keys (signed 64-bit ordered images of eigenvalues) are
// loaded one per cycle together with a 3-bit label; each is tagged with its load
// position. Up to MAX_KEYS keys are kept; further keys are dropped and the overflow
// bit is raised on every result of that set. The item with last set closes the set
// (it is dropped too if the store is full) and starts the sort; no new item is
// accepted until the last result of the set has left. For each position i the sort
// streams positions i..n-1 out of the key memory (one registered read per cycle,
// beside one write port), keeps the first strict minimum (or maximum when the order
// bit written through cfg_wdata is 1), and then swaps position i with the winner by
// two writes, ST_SWAP_I then ST_SWAP_K. Each result is then read, registered and
// handed over under ready before the next is read, with source_index giving the load
// position to move eigenvector columns by; last_out marks the final result.
module labeled_eigen_selection_sort_unit #(
  parameter int unsigned MAX_KEYS = lsort_pkg::MAX_KEYS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  lsort_in_if.sink      in_ch,
  lsort_out_if.source   out_ch
);
  import lsort_pkg::*;

  localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);

  // Key memory and its registered read data.
  lsort_entry_t mem [MAX_KEYS];
  lsort_entry_t rd_data_r;

  lsort_state_t state_r, state_nxt;

  logic          desc_r;
  logic [CW-1:0] load_cnt_r;
  logic          ovf_r;
  logic [AW-1:0] i_r;
  logic [CW-1:0] scan_j_r;
  logic          data_vld_r;
  logic [AW-1:0] data_idx_r;
  logic [AW-1:0] best_k_r;
  lsort_entry_t  best_r;
  lsort_entry_t  ent_i_r;
  logic [CW-1:0] emit_p_r;

  logic          out_valid_r;
  lsort_entry_t  out_ent_r;
  logic          out_ovf_r;
  logic          out_last_r;

  // Control outputs of the sequencer.
  logic          in_ready;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  lsort_entry_t  mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic          in_acc;
  logic          has_room;
  logic [CW-1:0] n_after_load;
  logic          scan_issue;
  logic          scan_last;
  logic          better;
  logic          emit_last;
  logic [CW-1:0] i_ext;

  assign in_acc       = in_ch.valid && in_ready;
  assign has_room     = load_cnt_r < CW'(MAX_KEYS);
  assign n_after_load = has_room ? load_cnt_r + CW'(1) : load_cnt_r;
  assign i_ext        = CW'(i_r);
  assign scan_issue   = scan_j_r < load_cnt_r;
  assign scan_last    = data_vld_r && (CW'(data_idx_r) + CW'(1) == load_cnt_r);
  assign emit_last    = emit_p_r + CW'(1) == load_cnt_r;

  // Strict compare so that the first extreme of the scan wins.
  always_comb begin
    if (desc_r) begin
      better = best_r.key < rd_data_r.key;
    end else begin
      better = rd_data_r.key < best_r.key;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_ch.last) begin
          state_nxt = (n_after_load >= CW'(2)) ? ST_SCAN : ST_EMIT_RD;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_SWAP_I;
        end
      end
      ST_SWAP_I: state_nxt = ST_SWAP_K;
      ST_SWAP_K: begin
        state_nxt = (i_ext + CW'(2) < load_cnt_r) ? ST_SCAN : ST_EMIT_RD;
      end
      ST_EMIT_RD: state_nxt = ST_EMIT_LD;
      ST_EMIT_LD: state_nxt = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (out_ch.ready) begin
          state_nxt = out_last_r ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Sequencer outputs: handshake and memory port controls.
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = load_cnt_r[AW-1:0];
    mem_wdata = best_r;
    mem_raddr = scan_j_r[AW-1:0];
    case (state_r)
      ST_LOAD: begin
        in_ready        = 1'b1;
        mem_we          = in_ch.valid && has_room;
        mem_wdata.key   = in_ch.key;
        mem_wdata.label = in_ch.label;
        mem_wdata.idx   = IDX_W'(load_cnt_r);
      end
      ST_SWAP_I: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = best_r;
      end
      ST_SWAP_K: begin
        mem_we    = 1'b1;
        mem_waddr = best_k_r;
        mem_wdata = ent_i_r;
      end
      ST_EMIT_RD: mem_raddr = emit_p_r[AW-1:0];
      default: ;
    endcase
  end

  // Key memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      desc_r      <= 1'b0;
      load_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      data_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        desc_r <= cfg_wdata;
      end
      case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            load_cnt_r <= n_after_load;
            if (!has_room) begin
              ovf_r <= 1'b1;
            end
          end
          data_vld_r <= 1'b0;
        end
        ST_SCAN: data_vld_r <= scan_issue;
        ST_SWAP_K: data_vld_r <= 1'b0;
        ST_EMIT_LD: out_valid_r <= 1'b1;
        ST_EMIT_WAIT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              load_cnt_r <= '0;
              ovf_r      <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Scan and emit datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: begin
        i_r      <= '0;
        scan_j_r <= '0;
        emit_p_r <= '0;
      end
      ST_SCAN: begin
        if (scan_issue) begin
          scan_j_r   <= scan_j_r + CW'(1);
          data_idx_r <= scan_j_r[AW-1:0];
        end
        if (data_vld_r) begin
          if (data_idx_r == i_r) begin
            ent_i_r  <= rd_data_r;
            best_r   <= rd_data_r;
            best_k_r <= data_idx_r;
          end else if (better) begin
            best_r   <= rd_data_r;
            best_k_r <= data_idx_r;
          end
        end
      end
      ST_SWAP_K: begin
        i_r      <= i_r + AW'(1);
        scan_j_r <= i_ext + CW'(1);
      end
      ST_EMIT_LD: begin
        out_ent_r  <= rd_data_r;
        out_ovf_r  <= ovf_r;
        out_last_r <= emit_last;
      end
      ST_EMIT_WAIT: begin
        if (out_ch.ready) begin
          emit_p_r <= emit_p_r + CW'(1);
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_key   = out_ent_r.key;
  assign out_ch.sorted_label = out_ent_r.label;
  assign out_ch.source_index = out_ent_r.idx;
  assign out_ch.overflow     = out_ovf_r;
  assign out_ch.last_out     = out_last_r;

endmodule

// ===== tb/labeled_eigen_selection_sort_unit_tb.sv =====
`timescale 1ns / 100ps

module labeled_eigen_selection_sort_unit_tb;
  import lsort_pkg::*;

  localparam int unsigned CAPACITY = MAX_KEYS_DEF;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned MAX_PRINTED = 40;
  localparam int unsigned TOTAL_ITEMS = 210;
  localparam int unsigned SIDE_IN = 0;
  localparam int unsigned SIDE_OUT = 1;
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

  // One sorted entry as it leaves the block.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [LABEL_W-1:0]      label;
    logic [IDX_W-1:0]        src;
    logic                    ovf;
    logic                    last;
  } sorted_result_t;

  // Mirror of the key store. When a set closes it is sorted here the same way
  // the block sorts it, and the sorted entries wait for the block's results.
  class eigen_order_tracker;
    lsort_entry_t   slots[CAPACITY];
    int unsigned    fill = 0;
    bit             dropped = 1'b0;
    bit             descending = 1'b0;
    sorted_result_t pending_sorted[$];
    int unsigned    errors = 0;
    int unsigned    checked = 0;
    int unsigned    sets = 0;
    int unsigned    overflow_sets = 0;

    function void set_order(bit desc);
      descending = desc;
    endfunction

    function int unsigned pending();
      return pending_sorted.size();
    endfunction

    // Store or drop one accepted key; a last mark sorts the stored keys.
    function void note_key(logic signed [KEY_W-1:0] item_key,
                           logic [LABEL_W-1:0] item_label, logic item_last);
      lsort_entry_t   held;
      sorted_result_t r;
      int unsigned    win;
      if (fill < CAPACITY) begin
        slots[fill].key = item_key;
        slots[fill].label = item_label;
        slots[fill].idx = IDX_W'(fill);
        fill++;
      end else begin
        dropped = 1'b1;
      end
      if (!item_last) return;

      // Selection sort: strict compare, so the first extreme found wins.
      for (int unsigned i = 0; i + 1 < fill; i++) begin
        win = i;
        for (int unsigned j = i + 1; j < fill; j++) begin
          if (descending ? ($signed(slots[win].key) < $signed(slots[j].key))
                         : ($signed(slots[j].key) < $signed(slots[win].key)))
            win = j;
        end
        if (win != i) begin
          held = slots[i];
          slots[i] = slots[win];
          slots[win] = held;
        end
      end

      for (int unsigned p = 0; p < fill; p++) begin
        r.key = slots[p].key;
        r.label = slots[p].label;
        r.src = slots[p].idx;
        r.ovf = dropped;
        r.last = (p + 1 == fill);
        pending_sorted.push_back(r);
      end
      sets++;
      if (dropped) overflow_sets++;
      fill = 0;
      dropped = 1'b0;
    endfunction

    task report(string msg);
      errors++;
      // Past a few dozen lines a broken block only repeats itself.
      if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compare one accepted result with the oldest waiting entry.
    task check_sorted(sorted_result_t got);
      sorted_result_t want;
      if (pending_sorted.size() == 0) begin
        report($sformatf("result with nothing waiting, key %0d", got.key));
        return;
      end
      want = pending_sorted.pop_front();
      checked++;
      if (got.key !== want.key)
        report($sformatf("sorted_key %0d, wanted %0d", got.key, want.key));
      if (got.label !== want.label)
        report($sformatf("sorted_label %0d, wanted %0d", got.label, want.label));
      if (got.src !== want.src)
        report($sformatf("source_index %0d, wanted %0d", got.src, want.src));
      if (got.ovf !== want.ovf)
        report($sformatf("overflow %b, wanted %b", got.ovf, want.ovf));
      if (got.last !== want.last)
        report($sformatf("last_out %b, wanted %b", got.last, want.last));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  int unsigned calm[2];
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;

  eigen_order_tracker tracker = new();

  lsort_in_if  key_in();
  lsort_out_if sorted_out();

  labeled_eigen_selection_sort_unit #(.MAX_KEYS(CAPACITY)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(key_in),
    .out_ch(sorted_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Wait before the next item: a random gap or none, with runs of back-to-back items.
  function int unsigned draw_gap(int unsigned side);
    if (calm[side] > 0) begin
      calm[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  // Keys: full random, many small values for ties, the extremes and keys near them.
  function automatic logic signed [KEY_W-1:0] rand_key();
    logic signed [KEY_W-1:0] v;
    v = KEY_W'($urandom_range(0, 6));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return {$urandom, $urandom};
      4, 5, 6: return v - KEY_W'(3);
      7: return KEY_MAX;
      8: return KEY_MIN;
      default: return $urandom_range(0, 1) ? (KEY_MAX - v) : (KEY_MIN + v);
    endcase
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic send_item(input logic signed [KEY_W-1:0] k,
                           input logic [LABEL_W-1:0] l, input logic mark);
    int unsigned gap;
    gap = draw_gap(SIDE_IN);
    if (gap > 0) begin
      key_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_in.valid <= 1'b1;
    key_in.key <= k;
    key_in.label <= l;
    key_in.last <= mark;
    do @(posedge clk); while (key_in.ready !== 1'b1);
    tracker.note_key(k, l, mark);
    items_sent++;
  endtask

  task automatic send_random_set(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_item(rand_key(), LABEL_W'($urandom_range(0, 7)), i + 1 == n);
  endtask

  // Let every waiting result drain so the block is idle.
  task automatic settle();
    key_in.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_order(input bit desc);
    cfg_we <= 1'b1;
    cfg_wdata <= desc;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_order(desc);
  endtask

  // Result side: random stalls, one check per accepted item.
  initial begin
    sorted_result_t got;
    int unsigned    gap;
    sorted_out.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      gap = draw_gap(SIDE_OUT);
      if (gap > 0) begin
        sorted_out.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      sorted_out.ready <= 1'b1;
      do @(posedge clk); while (sorted_out.valid !== 1'b1);
      got.key = sorted_out.sorted_key;
      got.label = sorted_out.sorted_label;
      got.src = sorted_out.source_index;
      got.ovf = sorted_out.overflow;
      got.last = sorted_out.last_out;
      tracker.check_sorted(got);
    end
  end

  // Watchdog: a long stretch with no item moving either way ends the run.
  always @(posedge clk) begin
    if ((key_in.valid === 1'b1 && key_in.ready === 1'b1) ||
        (sorted_out.valid === 1'b1 && sorted_out.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus.
  initial begin
    int unsigned n;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    key_in.valid <= 1'b0;
    key_in.key <= '0;
    key_in.label <= '0;
    key_in.last <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Ascending: both key extremes, label extremes and a tie on zero.
    write_order(1'b0);
    send_item(KEY_W'(0), 3'd3, 1'b0);
    send_item(KEY_MAX, 3'd7, 1'b0);
    send_item(KEY_MIN, 3'd0, 1'b0);
    send_item(KEY_W'(-1), 3'd5, 1'b0);
    send_item(KEY_W'(1), 3'd2, 1'b0);
    send_item(KEY_W'(0), 3'd4, 1'b1);
    // A set of one key.
    send_item(KEY_MIN, 3'd7, 1'b1);
    // All keys equal: order must come out as loaded.
    send_item(KEY_W'(-1), 3'd0, 1'b0);
    send_item(KEY_W'(-1), 3'd1, 1'b0);
    send_item(KEY_W'(-1), 3'd2, 1'b0);
    send_item(KEY_W'(-1), 3'd3, 1'b1);

    // Descending with repeated keys, so swaps reorder the ties.
    settle();
    write_order(1'b1);
    send_item(KEY_W'(5), 3'd1, 1'b0);
    send_item(KEY_W'(5), 3'd2, 1'b0);
    send_item(KEY_W'(-9), 3'd3, 1'b0);
    send_item(KEY_W'(5), 3'd4, 1'b0);
    send_item(KEY_W'(-9), 3'd5, 1'b0);
    send_item(KEY_MAX, 3'd6, 1'b0);
    send_item(KEY_MIN, 3'd7, 1'b1);
    send_item(KEY_MAX, 3'd0, 1'b1);

    // A full store plus dropped keys; the closing item is dropped as well.
    settle();
    write_order(1'($urandom_range(0, 1)));
    send_random_set(CAPACITY + $urandom_range(1, 3));

    // Mostly small sets, now and then a larger one, order changed between sets.
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        write_order(1'($urandom_range(0, 1)));
      end
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      send_random_set(n);
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Sent %0d keys in %0d sets (%0d with dropped keys), both sort orders.",
             items_sent, tracker.sets, tracker.overflow_sets);
    $display("Compared %0d sorted results, %0d mismatches.",
             tracker.checked, tracker.errors);
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lsort_pkg.sv
hw/rtl/lsort_ifs.sv
hw/rtl/labeled_eigen_selection_sort_unit.sv
tb/labeled_eigen_selection_sort_unit_tb.sv
